### rtl/tmr_pkg.sv
// Shared types and constants for the Turing machine runner.
// Used by tmr_cfg_regs, tmr_rule_table and turing_machine_runner.
`default_nettype none

package tmr_pkg;

  // Command kinds.
  localparam logic [1:0] KIND_RULE   = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Head moves; any other code keeps the head in place.
  localparam logic [1:0] MOVE_LEFT  = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;

  localparam logic [7:0] BLANK_SYM = 8'h24;

  // Configuration register indexes and reset values.
  localparam int         APB_AW              = 4;
  localparam logic [1:0] REG_INITIAL_STATE   = 2'd0;
  localparam logic [1:0] REG_ACCEPT_MASK     = 2'd1;
  localparam logic [1:0] REG_STEP_LIMIT      = 2'd2;
  localparam logic [3:0] INITIAL_STATE_RST   = 4'd0;
  localparam logic [15:0] ACCEPT_MASK_RST    = 16'd0;
  localparam logic [7:0] STEP_LIMIT_RST      = 8'd100;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] from_state;
    logic [7:0] read_symbol;
    logic [7:0] write_symbol;
    logic [1:0] head_move;
    logic [3:0] next_state;
    logic [7:0] tape_symbol;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       timed_out;
    logic [3:0] halt_state;
    logic [5:0] head_position;
    logic [7:0] step_count;
  } res_t;

  typedef struct packed {
    logic [3:0]  initial_state;
    logic [15:0] accept_mask;
    logic [7:0]  step_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] write_symbol;
    logic [1:0] head_move;
    logic [3:0] next_state;
  } rule_entry_t;

endpackage

`default_nettype wire

### rtl/tmr_cfg_regs.sv
// APB configuration registers: initial state, accept mask and step limit.
// Depends on tmr_pkg for the register map, reset values and cfg_t.
`default_nettype none

module tmr_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tmr_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tmr_pkg::cfg_t                   cfg
);

  logic       wr_fire;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_fire   = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_state <= tmr_pkg::INITIAL_STATE_RST;
      cfg.accept_mask   <= tmr_pkg::ACCEPT_MASK_RST;
      cfg.step_limit    <= tmr_pkg::STEP_LIMIT_RST;
    end else if (wr_fire) begin
      case (reg_index)
        tmr_pkg::REG_INITIAL_STATE: cfg.initial_state <= pwdata[3:0];
        tmr_pkg::REG_ACCEPT_MASK:   cfg.accept_mask   <= pwdata[15:0];
        tmr_pkg::REG_STEP_LIMIT:    cfg.step_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      tmr_pkg::REG_INITIAL_STATE: prdata = {28'd0, cfg.initial_state};
      tmr_pkg::REG_ACCEPT_MASK:   prdata = {16'd0, cfg.accept_mask};
      tmr_pkg::REG_STEP_LIMIT:    prdata = {24'd0, cfg.step_limit};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tmr_rule_table.sv
// Transition table: one synchronous memory word per (state, symbol) slot,
// holding a valid bit and the rule entry. Depends on tmr_pkg for rule_entry_t.
`default_nettype none

module tmr_rule_table #(
  parameter int STATE_COUNT = 16,
  parameter int AW          = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire tmr_pkg::rule_entry_t wr_entry,
  input  wire logic [AW-1:0]        rd_addr,
  output logic                      rd_hit,
  output tmr_pkg::rule_entry_t      rd_entry,
  output logic                      ready
);

  localparam int DEPTH = STATE_COUNT * 256;
  localparam int WW    = $bits(tmr_pkg::rule_entry_t) + 1;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_word;
  logic [AW-1:0] sweep_addr;
  logic          sweeping;

  // After reset every slot is swept once to clear its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + AW'(1);
      if (sweep_addr == AW'(DEPTH - 1)) begin
        sweeping <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_entry};
    end
    rd_word <= mem[rd_addr];
  end

  assign rd_hit   = rd_word[WW-1];
  assign rd_entry = rd_word[WW-2:0];
  assign ready    = !sweeping;

endmodule

`default_nettype wire

### rtl/tmr_tape.sv
// Tape memory: one write and one read port, with registered read data.
// A read of the cell written in the same cycle returns the new symbol.
`default_nettype none

module tmr_tape #(
  parameter int TAPE_CELLS = 64,
  parameter int TW         = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [TW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [TW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [TAPE_CELLS];
  logic [7:0] mem_q;
  logic [7:0] fwd_data;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q    <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

`default_nettype wire

### rtl/turing_machine_runner.sv
// Turing machine runner: rule, append and clear commands complete in the idle state.
// A run steps through S_LOOKUP and S_APPLY for each transition (tape read, then rule
// read, both synchronous memories) and holds the command channel until it halts, or
// times out after step_limit+1 transitions; a result still waiting holds the run.
// After reset the rule table is swept with cmd_ready low.
`default_nettype none

module turing_machine_runner #(
  parameter int STATE_COUNT = 16,
  parameter int TAPE_CELLS  = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire tmr_pkg::cmd_t              cmd,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output tmr_pkg::res_t                   res,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tmr_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int SW = $clog2(STATE_COUNT);
  localparam int AW = SW + 8;
  localparam int TW = $clog2(TAPE_CELLS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_APPLY  = 6'b001000,
    S_DONE   = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  state_t               fsm;
  tmr_pkg::cfg_t        cfg;
  logic [3:0]           mstate;
  logic [TW-1:0]        head;
  logic [TW-1:0]        head_next;
  logic [TW-1:0]        last;
  logic [TW-1:0]        tape_used;
  logic [8:0]           count;
  logic                 timed_out;
  logic                 state_ok;
  logic                 cmd_fire;
  logic                 rule_hit;

  logic                 tape_we;
  logic [TW-1:0]        tape_waddr;
  logic [7:0]           tape_wdata;
  logic [TW-1:0]        tape_raddr;
  logic [7:0]           tape_rdata;

  logic                 rule_we;
  logic [AW-1:0]        rule_waddr;
  tmr_pkg::rule_entry_t rule_wentry;
  logic [AW-1:0]        rule_raddr;
  logic                 rule_rhit;
  tmr_pkg::rule_entry_t rule_rentry;
  logic                 table_ready;

  tmr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmr_rule_table #(
    .STATE_COUNT (STATE_COUNT),
    .AW          (AW)
  ) u_rules (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rule_we),
    .wr_addr  (rule_waddr),
    .wr_entry (rule_wentry),
    .rd_addr  (rule_raddr),
    .rd_hit   (rule_rhit),
    .rd_entry (rule_rentry),
    .ready    (table_ready)
  );

  tmr_tape #(
    .TAPE_CELLS (TAPE_CELLS),
    .TW         (TW)
  ) u_tape (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tape_we),
    .wr_addr (tape_waddr),
    .wr_data (tape_wdata),
    .rd_addr (tape_raddr),
    .rd_data (tape_rdata)
  );

  assign cmd_ready = (fsm == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign rule_hit  = state_ok && rule_rhit;

  always_comb begin
    case (rule_rentry.head_move)
      tmr_pkg::MOVE_LEFT:  head_next = (head != '0) ? head - TW'(1) : head;
      tmr_pkg::MOVE_RIGHT: head_next = (head < last) ? head + TW'(1) : head;
      default:             head_next = head;
    endcase
  end

  // Memory port selection for each phase.
  always_comb begin
    tape_we     = 1'b0;
    tape_waddr  = head;
    tape_wdata  = tmr_pkg::BLANK_SYM;
    tape_raddr  = head;
    rule_we     = 1'b0;
    rule_waddr  = {SW'(cmd.from_state), cmd.read_symbol};
    rule_wentry = '{write_symbol: cmd.write_symbol, head_move: cmd.head_move,
                    next_state: cmd.next_state};
    rule_raddr  = {SW'(mstate), tape_rdata};
    case (fsm)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = '0;
      end
      S_IDLE: begin
        tape_raddr = TW'(1);
        if (cmd_fire) begin
          case (cmd.kind)
            tmr_pkg::KIND_RULE: begin
              rule_we = (int'(cmd.from_state) < STATE_COUNT);
            end
            tmr_pkg::KIND_APPEND: begin
              tape_we    = (tape_used < TW'(TAPE_CELLS - 1));
              tape_waddr = tape_used;
              tape_wdata = cmd.tape_symbol;
            end
            tmr_pkg::KIND_RUN: begin
              tape_we    = 1'b1;
              tape_waddr = tape_used;
            end
            tmr_pkg::KIND_CLEAR: begin
              tape_we    = 1'b1;
              tape_waddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_APPLY: begin
        if (rule_hit) begin
          tape_we    = 1'b1;
          tape_wdata = rule_rentry.write_symbol;
          tape_raddr = head_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_CLEAR;
      tape_used <= TW'(1);
      res_valid <= 1'b0;
    end else begin
      if (fsm == S_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (fsm)
        S_CLEAR: begin
          if (table_ready) begin
            fsm <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.kind)
              tmr_pkg::KIND_APPEND: begin
                if (tape_used < TW'(TAPE_CELLS - 1)) begin
                  tape_used <= tape_used + TW'(1);
                end
              end
              tmr_pkg::KIND_CLEAR: tape_used <= TW'(1);
              tmr_pkg::KIND_RUN:   fsm <= S_LOOKUP;
              default: ;
            endcase
          end
        end
        S_LOOKUP: begin
          fsm <= (count > {1'b0, cfg.step_limit}) ? S_DONE : S_APPLY;
        end
        S_APPLY: begin
          fsm <= rule_hit ? S_LOOKUP : S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  // Run datapath and result register.
  always_ff @(posedge clk) begin
    case (fsm)
      S_IDLE: begin
        if (cmd_fire && cmd.kind == tmr_pkg::KIND_RUN) begin
          mstate    <= cfg.initial_state;
          head      <= TW'(1);
          last      <= tape_used;
          count     <= '0;
          timed_out <= 1'b0;
        end
      end
      S_LOOKUP: begin
        timed_out <= (count > {1'b0, cfg.step_limit});
        state_ok  <= (int'(mstate) < STATE_COUNT);
      end
      S_APPLY: begin
        if (rule_hit) begin
          head   <= head_next;
          mstate <= rule_rentry.next_state;
          count  <= count + 9'd1;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          res.accepted      <= !timed_out && cfg.accept_mask[mstate];
          res.timed_out     <= timed_out;
          res.halt_state    <= mstate;
          res.head_position <= 6'(head);
          res.step_count    <= count[8] ? 8'hFF : count[7:0];
        end
      end
      default: ;
    endcase
  end

  // A lookup is only issued after the limit check passed.
  assert property (@(posedge clk) disable iff (rst)
    (fsm == S_APPLY) |-> (count <= {1'b0, cfg.step_limit}))
    else $error("transition attempted beyond the step limit");

  // The head stays between the leading blank and the trailing blank.
  assert property (@(posedge clk) disable iff (rst)
    (fsm == S_LOOKUP || fsm == S_APPLY) |-> (head <= last))
    else $error("head left the tape");

  // A matching rule always leads to another lookup.
  assert property (@(posedge clk) disable iff (rst)
    (fsm == S_APPLY && rule_hit) |=> (fsm == S_LOOKUP))
    else $error("run stopped although a rule matched");

  // A timed-out run never reports acceptance.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.accepted && res.timed_out))
    else $error("result both accepted and timed out");

  // No command is taken while the rule table is being swept.
  assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> table_ready)
    else $error("command ready during the table sweep");

endmodule

`default_nettype wire

### tb/turing_machine_runner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for turing_machine_runner: loads rule tables and tapes,
// starts runs and checks each run outcome against a behavioral model of the machine.
// Depends on tmr_pkg and the turing_machine_runner RTL.

module turing_machine_runner_tb;

  localparam int STATE_COUNT = 16;
  localparam int TAPE_CELLS = 64;
  localparam int RULE_SLOTS = STATE_COUNT * 256;
  localparam logic [1:0] MOVE_STAY = 2'd2;
  localparam logic [1:0] MOVE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET = 600;
  localparam int RUN_TARGET = 30;
  localparam int PHASE_ITEMS = 60;

  class tm_scoreboard;
    bit rule_valid [RULE_SLOTS];
    tmr_pkg::rule_entry_t rule_mem [RULE_SLOTS];
    logic [7:0] tape_mem [TAPE_CELLS];
    int tape_used;
    logic [3:0] initial_state;
    logic [15:0] accept_mask;
    logic [7:0] step_limit;
    tmr_pkg::res_t outcome_q [$];
    int mismatches;
    int runs;
    int timeouts;
    int accepts;

    function new();
      tape_mem[0] = tmr_pkg::BLANK_SYM;
      tape_used = 1;
      initial_state = tmr_pkg::INITIAL_STATE_RST;
      accept_mask = tmr_pkg::ACCEPT_MASK_RST;
      step_limit = tmr_pkg::STEP_LIMIT_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        tmr_pkg::REG_INITIAL_STATE: initial_state = value[3:0];
        tmr_pkg::REG_ACCEPT_MASK: accept_mask = value[15:0];
        tmr_pkg::REG_STEP_LIMIT: step_limit = value[7:0];
        default: ;
      endcase
    endfunction

    // Executes one run on the modeled tape and rule table.
    function tmr_pkg::res_t simulate_run();
      int last;
      int head;
      int count;
      bit timeout;
      logic [3:0] st;
      logic [11:0] slot;
      tmr_pkg::rule_entry_t hit;
      tmr_pkg::res_t r;
      last = tape_used;
      tape_mem[last] = tmr_pkg::BLANK_SYM;
      st = initial_state;
      head = 1;
      count = 0;
      timeout = 1'b0;
      while (1'b1) begin
        if (count > step_limit) begin
          timeout = 1'b1;
          break;
        end
        slot = {st, tape_mem[head]};
        if (!rule_valid[slot]) break;
        hit = rule_mem[slot];
        tape_mem[head] = hit.write_symbol;
        if (hit.head_move == tmr_pkg::MOVE_LEFT) begin
          if (head != 0) head--;
        end else if (hit.head_move == tmr_pkg::MOVE_RIGHT) begin
          if (head < last) head++;
        end
        st = hit.next_state;
        count++;
      end
      r.accepted = !timeout && accept_mask[st];
      r.timed_out = timeout;
      r.halt_state = st;
      r.head_position = head[5:0];
      r.step_count = (count > 255) ? 8'd255 : 8'(count);
      runs++;
      if (timeout) timeouts++;
      if (r.accepted) accepts++;
      return r;
    endfunction

    function void note_cmd(tmr_pkg::cmd_t c);
      case (c.kind)
        tmr_pkg::KIND_RULE: begin
          rule_valid[{c.from_state, c.read_symbol}] = 1'b1;
          rule_mem[{c.from_state, c.read_symbol}] = {c.write_symbol, c.head_move, c.next_state};
        end
        tmr_pkg::KIND_APPEND: begin
          // The last cell stays reserved for the trailing blank.
          if (tape_used < TAPE_CELLS - 1) begin
            tape_mem[tape_used] = c.tape_symbol;
            tape_used++;
          end
        end
        tmr_pkg::KIND_CLEAR: begin
          tape_used = 1;
          tape_mem[0] = tmr_pkg::BLANK_SYM;
        end
        tmr_pkg::KIND_RUN: outcome_q.push_back(simulate_run());
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(tmr_pkg::res_t got);
      tmr_pkg::res_t want;
      if (outcome_q.size() == 0) begin
        $error("run outcome with no run outstanding: %p", got);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
      compare_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
      compare_field("halt_state", 8'(want.halt_state), 8'(got.halt_state));
      compare_field("head_position", 8'(want.head_position), 8'(got.head_position));
      compare_field("step_count", want.step_count, got.step_count);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  tmr_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  tmr_pkg::res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tmr_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit steady = 1'b0;
  int items_sent = 0;
  int stall_cycles = 0;
  tm_scoreboard sb;

  turing_machine_runner #(
    .STATE_COUNT(STATE_COUNT),
    .TAPE_CELLS(TAPE_CELLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready) sb.check_outcome(res);
    res_ready <= steady || ($urandom_range(99) >= 13);
  end

  // Ends the run when neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready === 1'b1) || (res_valid === 1'b1 && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tmr_pkg::cmd_t noise_cmd();
    tmr_pkg::cmd_t c;
    c.kind = 2'($urandom_range(3));
    c.from_state = 4'($urandom_range(15));
    c.read_symbol = 8'($urandom_range(255));
    c.write_symbol = 8'($urandom_range(255));
    c.head_move = 2'($urandom_range(3));
    c.next_state = 4'($urandom_range(15));
    c.tape_symbol = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic tmr_pkg::cmd_t make_rule(logic [3:0] src_state, logic [7:0] rd,
                                              logic [7:0] wr, logic [1:0] mv,
                                              logic [3:0] nx);
    tmr_pkg::cmd_t c;
    c = noise_cmd();
    c.kind = tmr_pkg::KIND_RULE;
    c.from_state = src_state;
    c.read_symbol = rd;
    c.write_symbol = wr;
    c.head_move = mv;
    c.next_state = nx;
    return c;
  endfunction

  function automatic tmr_pkg::cmd_t make_plain(logic [1:0] kind, logic [7:0] sym);
    tmr_pkg::cmd_t c;
    c = noise_cmd();
    c.kind = kind;
    c.tape_symbol = sym;
    return c;
  endfunction

  task automatic send_cmd(input tmr_pkg::cmd_t c);
    while (!steady && $urandom_range(99) < 13) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    sb.note_cmd(c);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Holds the command channel until every run has reported and the block has settled.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One well-formed program: rules over a small alphabet, usually a fresh tape, then one or two runs.
  task automatic load_and_run(input logic [3:0] start);
    logic [7:0] alpha [4];
    logic [3:0] states [4];
    logic [7:0] base;
    logic [7:0] wr;
    logic [1:0] mv;
    int pick;
    int n_rules;
    int n_syms;
    base = 8'($urandom_range(255));
    alpha[0] = base;
    alpha[1] = base + 8'd1;
    alpha[2] = base + 8'd2;
    alpha[3] = tmr_pkg::BLANK_SYM;
    states[0] = start;
    for (int i = 1; i < 4; i++) states[i] = 4'($urandom_range(15));
    n_rules = $urandom_range(3, 14);
    for (int i = 0; i < n_rules; i++) begin
      wr = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : alpha[$urandom_range(3)];
      pick = $urandom_range(9);
      mv = (pick < 4) ? tmr_pkg::MOVE_LEFT : (pick < 8) ? tmr_pkg::MOVE_RIGHT :
           (pick == 8) ? MOVE_STAY : MOVE_SPARE;
      send_cmd(make_rule(states[$urandom_range(3)], alpha[$urandom_range(3)], wr, mv,
                         states[$urandom_range(3)]));
    end
    if ($urandom_range(9) != 0) begin
      send_cmd(make_plain(tmr_pkg::KIND_CLEAR, 8'($urandom_range(255))));
    end
    // Now and then the tape is overfilled so that appends get dropped.
    n_syms = ($urandom_range(19) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
    repeat (n_syms) send_cmd(make_plain(tmr_pkg::KIND_APPEND, alpha[$urandom_range(3)]));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'($urandom_range(255))));
    if ($urandom_range(3) == 0) begin
      send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'($urandom_range(255))));
    end
  endtask

  initial begin
    int phase;
    int target;
    logic [3:0] cur_init;
    logic [15:0] cur_mask;
    logic [7:0] cur_limit;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: start state 0, nothing accepts, limit of 100 steps.
    send_cmd(make_plain(tmr_pkg::KIND_CLEAR, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'hFF));
    send_cmd(make_rule(4'd0, tmr_pkg::BLANK_SYM, 8'hFF, tmr_pkg::MOVE_LEFT, 4'd15));
    send_cmd(make_rule(4'd15, tmr_pkg::BLANK_SYM, 8'h00, MOVE_SPARE, 4'd15));
    send_cmd(make_rule(4'd15, 8'h00, 8'h00, tmr_pkg::MOVE_LEFT, 4'd14));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'hFF));
    send_cmd(make_plain(tmr_pkg::KIND_CLEAR, 8'hFF));
    send_cmd(make_plain(tmr_pkg::KIND_APPEND, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_APPEND, 8'hFF));
    send_cmd(make_rule(4'd0, 8'h00, 8'h55, tmr_pkg::MOVE_RIGHT, 4'd0));
    send_cmd(make_rule(4'd0, 8'hFF, 8'hAA, tmr_pkg::MOVE_RIGHT, 4'd0));
    send_cmd(make_rule(4'd15, 8'hAA, 8'hAA, tmr_pkg::MOVE_RIGHT, 4'd13));
    // The head runs into the trailing cell and must stay there.
    send_cmd(make_rule(4'd13, 8'hFF, 8'hFF, tmr_pkg::MOVE_RIGHT, 4'd12));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'h00));
    send_cmd(make_rule(4'd7, 8'hAA, 8'hAA, MOVE_STAY, 4'd7));
    send_cmd(make_rule(4'd15, 8'hFF, 8'hFF, MOVE_STAY, 4'd0));

    // A self-loop against the largest limit saturates the step count.
    wait_idle();
    write_reg(tmr_pkg::REG_INITIAL_STATE, 32'd7);
    write_reg(tmr_pkg::REG_ACCEPT_MASK, 32'hFFFF);
    write_reg(tmr_pkg::REG_STEP_LIMIT, 32'd255);
    send_cmd(make_plain(tmr_pkg::KIND_CLEAR, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_APPEND, 8'hAA));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'h00));

    wait_idle();
    write_reg(tmr_pkg::REG_STEP_LIMIT, 32'd0);
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_CLEAR, 8'h00));
    send_cmd(make_plain(tmr_pkg::KIND_RUN, 8'h00));

    phase = 0;
    while (items_sent < ITEM_TARGET || sb.runs < RUN_TARGET) begin
      wait_idle();
      steady = (phase == 2);
      cur_init = 4'($urandom_range(15));
      case ($urandom_range(3))
        0: cur_mask = 16'h0000;
        1: cur_mask = 16'hFFFF;
        default: cur_mask = 16'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(5))
        0: cur_limit = 8'd0;
        1: cur_limit = 8'd255;
        2: cur_limit = 8'd1;
        3: cur_limit = 8'($urandom_range(255));
        default: cur_limit = 8'($urandom_range(2, 60));
      endcase
      write_reg(tmr_pkg::REG_INITIAL_STATE, 32'(cur_init));
      write_reg(tmr_pkg::REG_ACCEPT_MASK, 32'(cur_mask));
      write_reg(tmr_pkg::REG_STEP_LIMIT, 32'(cur_limit));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 12) send_cmd(noise_cmd());
        else load_and_run(cur_init);
      end
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    $display("Sent %0d commands over %0d random phases; %0d runs checked", items_sent, phase,
             sb.runs);
    $display("Run outcomes: %0d accepted, %0d timed out", sb.accepts, sb.timeouts);
    if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
